FILE: hdl/sptd_pkg.sv
// Shared types, constants and the CRC-8 column table for the scratchpad decode unit.
package sptd_pkg;

   localparam int BYTE_W      = 8;
   localparam int PAD_BYTES   = 8;
   localparam int MSG_W       = BYTE_W * PAD_BYTES;
   localparam int TEMP_W      = 16;
   localparam int RES_W       = 4;
   localparam int DIV_W       = 8;
   localparam int NUM_W       = 15;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_DATA_W  = 72;
   localparam int REQ_USER_W  = 9;
   localparam int RSP_DATA_W  = 24;
   localparam int RSP_USER_W  = 2;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [BYTE_W-1:0] CRC_POLY        = 8'h8C;
   localparam logic [TEMP_W-1:0] HALF_DEG_MASK   = 16'hFFF0;
   localparam logic [TEMP_W-1:0] LEGACY_OFFSET   = 16'd16;
   localparam logic [BYTE_W-1:0] LEGACY_RESET    = 8'd16;
   localparam logic [TEMP_W-1:0] DISCONN_RESET   = 16'hE480;
   localparam logic [BYTE_W-1:0] RES_9_CODE      = 8'h1F;
   localparam logic [BYTE_W-1:0] RES_10_CODE     = 8'h3F;
   localparam logic [BYTE_W-1:0] RES_11_CODE     = 8'h5F;
   localparam logic [BYTE_W-1:0] RES_12_CODE     = 8'h7F;
   localparam logic [RES_W-1:0]  RES_9           = 4'd9;
   localparam logic [RES_W-1:0]  RES_10          = 4'd10;
   localparam logic [RES_W-1:0]  RES_11          = 4'd11;
   localparam logic [RES_W-1:0]  RES_12          = 4'd12;
   localparam logic [RES_W-1:0]  RES_UNKNOWN     = 4'd0;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEGACY_FAMILY = 1'b0,
      CSR_DISCONNECTED  = 1'b1
   } csr_index_type;

   // classified item handed from front to back
   typedef struct packed {
      logic              connected;
      logic              div_fault;
      logic              use_quot;
      logic              neg;
      logic [RES_W-1:0]  resolution;
      logic [TEMP_W-1:0] temp_base;
      logic [NUM_W-1:0]  num;
      logic [DIV_W-1:0]  divisor;
   } fe_item_type;

   typedef struct packed {
      fe_item_type       item;
      logic [DIV_W-1:0]  rem;
      logic [NUM_W-1:0]  quot;
   } div_stage_type;

   typedef struct packed {
      logic              full;
      logic              not_empty;
      logic [QCNT_W-1:0] count;
   } queue_status_type;

   typedef logic [MSG_W-1:0][BYTE_W-1:0] crc_cols_type;

   // CRC of a message with only bit j set; the CRC is linear with zero seed
   function automatic crc_cols_type crc_columns();
      crc_cols_type cols;
      logic [BYTE_W-1:0] crc;
      logic [BYTE_W-1:0] v;
      logic mix;
      for (int j = 0; j < MSG_W; j++) begin
         crc = '0;
         for (int i = 0; i < PAD_BYTES; i++) begin
            v = (i == j / BYTE_W) ? (BYTE_W'(1) << (j % BYTE_W)) : '0;
            for (int b = 0; b < BYTE_W; b++) begin
               mix = crc[0] ^ v[0];
               crc = crc >> 1;
               if (mix) crc = crc ^ CRC_POLY;
               v = v >> 1;
            end
         end
         cols[j] = crc;
      end
      return cols;
   endfunction

   localparam crc_cols_type CRC_COLS = crc_columns();

   // XOR of the columns of all set bits, a flat reduction tree
   function automatic logic [BYTE_W-1:0] crc8_parallel(logic [MSG_W-1:0] msg);
      logic [BYTE_W-1:0] crc;
      crc = '0;
      for (int j = 0; j < MSG_W; j++) begin
         crc = crc ^ (msg[j] ? CRC_COLS[j] : '0);
      end
      return crc;
   endfunction

endpackage

FILE: hdl/sptd_front.sv
// Front end: configuration registers, CRC check and classification of each scratchpad.
module sptd_front import sptd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic [REQ_USER_W-1:0]  req_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output logic                   push,
   output fe_item_type            push_item,
   input  logic                   queue_full
);

   logic [BYTE_W-1:0] legacy_code_ff, legacy_code_in;
   logic [TEMP_W-1:0] disconn_ff, disconn_in;
   logic              valid_ff, valid_in;
   fe_item_type       item_ff, item_in;

   logic              read_ok;
   logic [BYTE_W-1:0] family;
   logic [BYTE_W-1:0] lsb, msb, cfg_byte, remain, per, crc_rx;
   logic              legacy, crc_ok, connected;
   logic [TEMP_W-1:0] temp_std, temp_leg;
   logic [DIV_W:0]    diff;
   logic [DIV_W-1:0]  mag;
   logic [RES_W-1:0]  res_cfg;
   logic              advance;

   assign csr_ready = 1'b1;

   always_comb begin
      legacy_code_in = legacy_code_ff;
      disconn_in     = disconn_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEGACY_FAMILY: legacy_code_in = csr_data[BYTE_W-1:0];
            CSR_DISCONNECTED:  disconn_in     = csr_data;
            default:           ;
         endcase
      end
   end

   assign read_ok  = req_tuser[0];
   assign family   = req_tuser[8:1];
   assign lsb      = req_tdata[7:0];
   assign msb      = req_tdata[15:8];
   assign cfg_byte = req_tdata[39:32];
   assign remain   = req_tdata[55:48];
   assign per      = req_tdata[63:56];
   assign crc_rx   = req_tdata[71:64];

   assign legacy    = (family == legacy_code_ff);
   assign crc_ok    = (crc8_parallel(req_tdata[MSG_W-1:0]) == crc_rx);
   assign connected = read_ok && crc_ok;

   assign temp_std = {msb[4:0], lsb, 3'b000};
   // drop the half-degree bit, scale up, then take off an eighth of a degree
   assign temp_leg = {temp_std[12:4], 4'b0000, 3'b000} - LEGACY_OFFSET;

   assign diff = {1'b0, per} - {1'b0, remain};
   assign mag  = diff[DIV_W] ? DIV_W'(-diff) : diff[DIV_W-1:0];

   always_comb begin
      unique case (cfg_byte)
         RES_12_CODE: res_cfg = RES_12;
         RES_11_CODE: res_cfg = RES_11;
         RES_10_CODE: res_cfg = RES_10;
         RES_9_CODE:  res_cfg = RES_9;
         default:     res_cfg = RES_UNKNOWN;
      endcase
   end

   always_comb begin
      item_in.connected  = connected;
      item_in.div_fault  = connected && legacy && (per == '0);
      item_in.use_quot   = connected && legacy && (per != '0);
      item_in.neg        = diff[DIV_W];
      item_in.resolution = legacy ? RES_12 : (connected ? res_cfg : RES_UNKNOWN);
      item_in.temp_base  = !connected ? disconn_ff : (legacy ? temp_leg : temp_std);
      item_in.num        = {mag, 7'b0000000};
      item_in.divisor    = per;
   end

   assign advance    = !valid_ff || !queue_full;
   assign req_tready = advance;
   assign valid_in   = advance ? req_tvalid : valid_ff;
   assign push       = valid_ff && !queue_full;
   assign push_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         legacy_code_ff <= LEGACY_RESET;
         disconn_ff     <= DISCONN_RESET;
         valid_ff       <= 1'b0;
      end else begin
         legacy_code_ff <= legacy_code_in;
         disconn_ff     <= disconn_in;
         valid_ff       <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && req_tvalid) item_ff <= item_in;
   end

endmodule

FILE: hdl/sptd_queue.sv
// Short queue of classified items between front and back end.
module sptd_queue import sptd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  fe_item_type      push_item,
   input  logic             pop,
   output fe_item_type      head_item,
   output queue_status_type status
);

   fe_item_type       entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign status.full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign status.count     = count_ff;
   assign head_item        = entry_ff[rd_ptr_ff];

   assign do_push = push && !status.full;
   assign do_pop  = pop && status.not_empty;

   always_comb begin
      wr_ptr_in = do_push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = QCNT_W'(count_ff + 1'b1);
      else if (do_pop && !do_push) count_in = QCNT_W'(count_ff - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_item;
   end

endmodule

FILE: hdl/sptd_back.sv
// Back end: pipelined restoring divider for the legacy extension and the result register.
module sptd_back import sptd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  fe_item_type           head_item,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [RSP_USER_W-1:0] rsp_tuser
);

   div_stage_type     stage_ff [NUM_W];
   div_stage_type     stage_in [NUM_W];
   logic              valid_ff [NUM_W];
   logic              out_valid_ff, out_valid_in;
   logic [TEMP_W-1:0] temp_ff, temp_in;
   logic              conn_ff, fault_ff;
   logic [RES_W-1:0]  res_ff;
   logic              advance;
   div_stage_type     last;
   logic [TEMP_W-1:0] quot_s;

   // one global stall: every stage moves when the result register can take an item
   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = advance && head_valid;

   // stage s settles quotient bit NUM_W-1-s
   always_comb begin
      div_stage_type src;
      logic [DIV_W:0] trial;
      for (int s = 0; s < NUM_W; s++) begin
         if (s == 0) begin
            src.item = head_item;
            src.rem  = '0;
            src.quot = '0;
         end else begin
            src = stage_ff[s-1];
         end
         trial       = {src.rem, src.item.num[NUM_W-1-s]};
         stage_in[s] = src;
         if (trial >= {1'b0, src.item.divisor}) begin
            stage_in[s].rem                = DIV_W'(trial - {1'b0, src.item.divisor});
            stage_in[s].quot[NUM_W-1-s]    = 1'b1;
         end else begin
            stage_in[s].rem = trial[DIV_W-1:0];
         end
      end
   end

   assign last   = stage_ff[NUM_W-1];
   assign quot_s = last.item.neg ? TEMP_W'(-{1'b0, last.quot}) : TEMP_W'({1'b0, last.quot});
   assign temp_in = last.item.use_quot ? TEMP_W'(last.item.temp_base + quot_s)
                                       : last.item.temp_base;
   assign out_valid_in = advance ? valid_ff[NUM_W-1] : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NUM_W; s++) valid_ff[s] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (advance) begin
            valid_ff[0] <= head_valid;
            for (int s = 1; s < NUM_W; s++) valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < NUM_W; s++) stage_ff[s] <= stage_in[s];
         temp_ff  <= temp_in;
         conn_ff  <= last.item.connected;
         fault_ff <= last.item.div_fault;
         res_ff   <= last.item.resolution;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'b0000, res_ff, temp_ff};
   assign rsp_tuser  = {fault_ff, conn_ff};

endmodule

FILE: hdl/scratchpad_temperature_decode_unit.sv
// Top level of the scratchpad temperature decode unit.
//
// Usage: one item on req_ is a full nine-byte scratchpad plus the bus read
// status and the family code; each item gives exactly one item on rsp_.
// The csr_ channel writes register 0 (legacy family code, reset 16) and
// register 1 (disconnected temperature code, reset -7040); it is always
// ready and should only be written while the unit is empty.
// Path from req_ accept to rsp_tvalid with no stall: the classified item
// is registered at the accept edge, then passes through the queue, the
// fifteen divider stages (one quotient bit per stage) and the result
// register.
// Throughput: one item per cycle while no result waits on rsp_tready; the
// divider pipeline and the 4-entry queue each take an item every cycle.
// If rsp_tready is low while a result waits, the result register holds and
// the divider pipeline freezes; the queue and the front register then take
// up to five more items before req_tready falls.
// Synchronous reset empties the pipeline and queue and restores both
// configuration registers.
module scratchpad_temperature_decode_unit import sptd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [7:0] byte 0 (temperature low), [15:8] byte 1 (temperature high), ...
   // [63:56] count_per_degree, [71:64] crc_byte
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // [0] read_ok, [8:1] family_code
   input  logic [REQ_USER_W-1:0]  req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [15:0] temp_raw, [19:16] resolution, [23:20] zero
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // [0] connected, [1] div_fault
   output logic [RSP_USER_W-1:0]  rsp_tuser,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic             push, pop;
   fe_item_type      push_item, head_item;
   queue_status_type q_status;

   sptd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .push       (push),
      .push_item  (push_item),
      .queue_full (q_status.full)
   );

   sptd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   sptd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_status.not_empty),
      .head_item  (head_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a divide fault only arises on a connected legacy read
   a_fault_connected: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tuser[0])
      else $error("div_fault without connected");

   a_res_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[19:16] == RES_UNKNOWN) || (rsp_tdata[19:16] == RES_9) ||
                     (rsp_tdata[19:16] == RES_10) || (rsp_tdata[19:16] == RES_11) ||
                     (rsp_tdata[19:16] == RES_12))
      else $error("illegal resolution code");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_status.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid && !q_status.not_empty)
      else $error("output or queue not empty after reset");

endmodule
